@@ hw/rtl/wcrc_pkg.sv @@
// Shared types, constants and CRC function for the word CRC response deframer.
`default_nettype none

package wcrc_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgPoly   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInit   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgXorOut = 2'd2;

  // Register reset values
  localparam logic [7:0] PolyReset   = 8'h31;
  localparam logic [7:0] InitReset   = 8'hFF;
  localparam logic [7:0] XorOutReset = 8'h00;

  // Group layout: word0 hi, word0 lo, crc0, word1 hi, word1 lo, crc1
  localparam int unsigned PosW = 3;
  localparam logic [PosW-1:0] PosW0Hi  = 3'd0;
  localparam logic [PosW-1:0] PosW0Lo  = 3'd1;
  localparam logic [PosW-1:0] PosCrc0  = 3'd2;
  localparam logic [PosW-1:0] PosW1Hi  = 3'd3;
  localparam logic [PosW-1:0] PosW1Lo  = 3'd4;
  localparam logic [PosW-1:0] PosCrc1  = 3'd5;

  typedef struct packed {
    logic [7:0] poly;
    logic [7:0] init;
    logic [7:0] xorout;
  } cfg_t;

  // Fold one byte into an MSB-first CRC-8 register
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/word_crc_response_deframer_top.sv @@
// A group result becomes valid in the cycle after its sixth byte is accepted.
// Throughput: one byte per cycle while input ready is high; the byte CRC update is
// an unrolled 8-step XOR network that feeds the running CRC register.
// Input ready stays high while the result register is empty or being drained.
// Reset clears group position, flags and the result valid; config registers
// return to polynomial 0x31, start value 0xFF and output XOR 0x00.
`default_nettype none

module word_crc_response_deframer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Byte stream in
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  wire logic [0:0]                    s_axis_tuser,   // [0] start_of_response
  // Group result out
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [31:0]                        m_axis_tdata,   // [31:0] value_bits
  output logic [2:0]                         m_axis_tuser,   // [0] first_word_bad,
                                                             // [1] second_word_bad,
                                                             // [2] any_error
  // Configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [wcrc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i
);
  import wcrc_pkg::*;

  cfg_t cfg;

  wcrc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]      crc_q, crc_d;
  logic [23:0]     held_q, held_d;
  logic [7:0]      low_q, low_d;
  logic            first_bad_q, first_bad_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     out_data_q, out_data_d;
  logic [2:0]      out_user_q, out_user_d;
  logic            in_fire;
  logic [7:0]      crc_seed;
  logic [7:0]      crc_next;
  logic            crc_bad;

  // Accept while the result register is empty or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Realign on a start flag or an out-of-range position
  assign pos_eff = (s_axis_tuser[0] || pos_q > PosCrc1) ? PosW0Hi : pos_q;

  // Byte CRC update, seeded with the start value on a word's first byte
  assign crc_seed = (pos_eff == PosW0Hi || pos_eff == PosW1Hi) ? cfg.init : crc_q;
  assign crc_next = crc8_byte(crc_seed, s_axis_tdata, cfg.poly);
  assign crc_bad  = (crc_q ^ cfg.xorout) != s_axis_tdata;

  // Advance group state for one accepted byte
  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    held_d      = held_q;
    low_d       = low_q;
    first_bad_d = first_bad_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (in_fire) begin
      pos_d = (pos_eff == PosCrc1) ? PosW0Hi : pos_eff + 3'd1;
      unique case (pos_eff)
        PosW0Hi: begin
          crc_d       = crc_next;
          held_d      = {s_axis_tdata, 16'h0000};
          first_bad_d = 1'b0;
        end
        PosW0Lo: begin
          crc_d       = crc_next;
          held_d      = {held_q[23:16], s_axis_tdata, 8'h00};
        end
        PosCrc0: begin
          first_bad_d = crc_bad;
          crc_d       = cfg.init;
        end
        PosW1Hi: begin
          crc_d       = crc_next;
          held_d      = {held_q[23:8], s_axis_tdata};
        end
        PosW1Lo: begin
          crc_d       = crc_next;
          low_d       = s_axis_tdata;
        end
        default: begin
          crc_d       = cfg.init;
          out_valid_d = 1'b1;
          out_data_d  = {held_q, low_q};
          out_user_d  = {first_bad_q || crc_bad, crc_bad, first_bad_q};
        end
      endcase
    end
  end

  // Control and payload state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosW0Hi;
      crc_q       <= InitReset;
      held_q      <= '0;
      low_q       <= '0;
      first_bad_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      held_q      <= held_d;
      low_q       <= low_d;
      first_bad_q <= first_bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  // Position never leaves the group range
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosCrc1)
    else $error("group position out of range");

  // A completed group always loads the result register
  a_group_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && pos_eff == PosCrc1) |=> m_axis_tvalid)
    else $error("completed group produced no result");

  // A new result only follows the last byte of a group
  a_rose_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_fire && pos_eff == PosCrc1))
    else $error("result appeared without a completed group");

  // Error summary agrees with the per-word flags
  a_any_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[2] == (m_axis_tuser[0] || m_axis_tuser[1])))
    else $error("error summary mismatch");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/wcrc_cfg_regs.sv @@
// Configuration register file: CRC polynomial, start value and output XOR.
`default_nettype none

module wcrc_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [wcrc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i,
  output wcrc_pkg::cfg_t                     cfg_o
);
  import wcrc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // Decode the write index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPoly:   cfg_d.poly   = cfg_data_i;
        CfgInit:   cfg_d.init   = cfg_data_i;
        CfgXorOut: cfg_d.xorout = cfg_data_i;
        default:   cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{poly: PolyReset, init: InitReset, xorout: XorOutReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire
